>>> rtl/core/tsvd_pkg.sv
// Package for the transport stream video codec detector.
// Holds the packet geometry, start code constants, result codes and shared types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package tsvd_pkg;

  // Packet geometry.
  localparam int PACKET_BYTES = 188;
  localparam int POS_W        = $clog2(PACKET_BYTES);

  // Field widths.
  localparam int DATA_W       = 8;
  localparam int PID_W        = 13;
  localparam int PID_HI_W     = PID_W - DATA_W;
  localparam int VIDEO_TYPE_W = 2;
  localparam int WINDOW_W     = 4 * DATA_W;
  localparam int NAL_TYPE_W   = 5;

  // Stream constants.
  localparam logic [DATA_W-1:0]     SYNC_VALUE  = 8'h47;
  localparam logic [WINDOW_W-1:0]   SEQ_CODE    = 32'h0000_01B3;
  localparam logic [WINDOW_W-1:0]   GOP_CODE    = 32'h0000_01B8;
  localparam logic [WINDOW_W-1:0]   H264_PREFIX = 32'h0000_0001;
  localparam logic [NAL_TYPE_W-1:0] NAL_SPS     = 5'd7;
  localparam logic [NAL_TYPE_W-1:0] NAL_PPS     = 5'd8;

  // Header byte offsets and the first offsets at which a whole code can end.
  localparam logic [POS_W-1:0] POS_SYNC      = POS_W'(0);
  localparam logic [POS_W-1:0] POS_PID_HI    = POS_W'(1);
  localparam logic [POS_W-1:0] POS_PID_LO    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_MPEG_MIN  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_H264_MIN  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(PACKET_BYTES - 1);

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_IDX_W  = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_VIDEO_PID = REG_IDX_W'(0);

  typedef enum logic [VIDEO_TYPE_W-1:0] {
    VT_NONE  = 2'd0,
    VT_MPEG2 = 2'd1,
    VT_H264  = 2'd2
  } video_type_e;

  // Start codes seen in the current packet.
  typedef struct packed {
    logic pps;
    logic sps;
    logic gop;
    logic seq;
  } tsvd_hits_t;

  // Evidence gathered over the whole buffer.
  typedef struct packed {
    logic found_h264;
    logic seen_sps;
    logic found_mpeg;
    logic seen_seq;
  } tsvd_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/tsvd_if.sv
// Handshake interfaces for the byte input and the result output channels.
// Depends on tsvd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ts_byte_if;
  import tsvd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ts_result_if;
  import tsvd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [VIDEO_TYPE_W-1:0] video_type;

  modport source (output valid, output video_type, input ready);
  modport sink   (input valid, input video_type, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tsvd_start_code_matcher.sv
// Start code comparator working on the byte shift register and the new byte.
// Depends on tsvd_pkg for the codes, offsets and the hit struct.
`timescale 1ns / 1ps
`default_nettype none

module tsvd_start_code_matcher (
  input  wire logic [tsvd_pkg::WINDOW_W-1:0] recent_bytes,
  input  wire logic [tsvd_pkg::DATA_W-1:0]   data_byte,
  input  wire logic [tsvd_pkg::POS_W-1:0]    byte_position,
  output tsvd_pkg::tsvd_hits_t               hits
);
  import tsvd_pkg::*;

  logic [WINDOW_W-1:0]   window;
  logic [NAL_TYPE_W-1:0] nal_type;
  logic                  mpeg_zone;
  logic                  h264_zone;

  assign window    = {recent_bytes[WINDOW_W-DATA_W-1:0], data_byte};
  assign nal_type  = data_byte[NAL_TYPE_W-1:0];
  // A four-byte MPEG-2 code must start at offset 4 or later.
  assign mpeg_zone = (byte_position >= POS_MPEG_MIN);
  // The H.264 prefix may start at offset 0, so the NAL byte sits at 4 or later.
  assign h264_zone = (byte_position >= POS_H264_MIN) && (recent_bytes == H264_PREFIX);

  assign hits.seq = mpeg_zone && (window == SEQ_CODE);
  assign hits.gop = mpeg_zone && (window == GOP_CODE);
  assign hits.sps = h264_zone && (nal_type == NAL_SPS);
  assign hits.pps = h264_zone && (nal_type == NAL_PPS);

endmodule

`default_nettype wire

>>> rtl/core/tsvd_packet_tracker.sv
// Packet tracker: byte offset, sync and PID capture, per-packet hits and buffer flags.
// Depends on tsvd_pkg and instantiates tsvd_start_code_matcher.
`timescale 1ns / 1ps
`default_nettype none

module tsvd_packet_tracker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire logic [tsvd_pkg::DATA_W-1:0] data_byte,
  input  wire logic                       last_byte,
  input  wire logic [tsvd_pkg::PID_W-1:0] video_pid,
  output tsvd_pkg::video_type_e           video_type
);
  import tsvd_pkg::*;

  logic [POS_W-1:0]    byte_position;
  logic [WINDOW_W-1:0] recent_bytes;
  logic [PID_W-1:0]    packet_pid;
  logic                sync_good;
  tsvd_hits_t          packet_hits;
  tsvd_flags_t         buffer_flags;

  logic [POS_W-1:0]    byte_position_next;
  logic [PID_W-1:0]    packet_pid_next;
  logic                sync_good_next;
  tsvd_hits_t          packet_hits_next;
  tsvd_flags_t         buffer_flags_next;
  tsvd_hits_t          match_hits;
  tsvd_hits_t          hits_acc;
  logic                packet_end;
  logic                packet_ok;

  tsvd_start_code_matcher u_matcher (
    .recent_bytes  (recent_bytes),
    .data_byte     (data_byte),
    .byte_position (byte_position),
    .hits          (match_hits)
  );

  assign packet_end = (byte_position == POS_LAST);

  always_comb begin
    sync_good_next  = sync_good;
    packet_pid_next = packet_pid;
    hits_acc        = packet_hits;
    if (byte_position == POS_SYNC) begin
      sync_good_next = (data_byte == SYNC_VALUE);
      hits_acc       = '0;
    end else if (byte_position == POS_PID_HI) begin
      packet_pid_next = {data_byte[PID_HI_W-1:0], {DATA_W{1'b0}}};
    end else if (byte_position == POS_PID_LO) begin
      packet_pid_next = {packet_pid[PID_W-1:DATA_W], data_byte};
    end
    hits_acc = hits_acc | match_hits;
  end

  // A whole packet with good sync on the chosen PID hands its hits to the buffer flags.
  assign packet_ok = packet_end && sync_good_next && (packet_pid_next == video_pid);

  always_comb begin
    buffer_flags_next = buffer_flags;
    if (packet_ok) begin
      buffer_flags_next.seen_seq   = buffer_flags.seen_seq | hits_acc.seq;
      buffer_flags_next.found_mpeg = buffer_flags.found_mpeg |
                                     (buffer_flags_next.seen_seq & hits_acc.gop);
      buffer_flags_next.seen_sps   = buffer_flags.seen_sps | hits_acc.sps;
      buffer_flags_next.found_h264 = buffer_flags.found_h264 |
                                     (buffer_flags_next.seen_sps & hits_acc.pps);
    end
    packet_hits_next   = packet_end ? '0 : hits_acc;
    byte_position_next = packet_end ? '0 : byte_position + POS_W'(1);
  end

  always_comb begin
    if (buffer_flags_next.found_mpeg) begin
      video_type = VT_MPEG2;
    end else if (buffer_flags_next.found_h264) begin
      video_type = VT_H264;
    end else begin
      video_type = VT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      recent_bytes  <= '0;
      packet_pid    <= '0;
      sync_good     <= 1'b0;
      packet_hits   <= '0;
      buffer_flags  <= '0;
    end else if (advance) begin
      if (last_byte) begin
        // End of buffer: start the next buffer from a clean slate.
        byte_position <= '0;
        recent_bytes  <= '0;
        packet_pid    <= '0;
        sync_good     <= 1'b0;
        packet_hits   <= '0;
        buffer_flags  <= '0;
      end else begin
        byte_position <= byte_position_next;
        recent_bytes  <= {recent_bytes[WINDOW_W-DATA_W-1:0], data_byte};
        packet_pid    <= packet_pid_next;
        sync_good     <= sync_good_next;
        packet_hits   <= packet_hits_next;
        buffer_flags  <= buffer_flags_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ts_video_codec_detector.sv
// Top level of the transport stream video codec detector.
// Depends on tsvd_pkg, tsvd_if.sv and tsvd_packet_tracker (with its matcher).
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Payload                   Handshake
// byte_in     in         data_byte[7:0], last_byte valid / ready
// result_out  out        video_type[1:0]           valid / ready
// apb         in         video_pid at byte 0       psel / penable / pready
//
// One byte is taken per clock cycle when the result side is not stalled. A byte
// is held in the input register; the per-byte work (offset, sync, PID, start
// code compare and buffer flags) is done combinationally while it is held, and
// the verdict of a buffer is loaded into the output register as its last byte
// moves on. Reset is synchronous; it clears the input and output valid flags,
// the tracker state and the video PID register. A stalled result only holds
// back a byte marked last; ordinary bytes keep flowing while the result waits.

module ts_video_codec_detector (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ts_byte_if.sink                            byte_in,
  ts_result_if.source                        result_out,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tsvd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tsvd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [tsvd_pkg::APB_DATA_W-1:0] prdata,
  output logic                               pready
);
  import tsvd_pkg::*;

  // Input register: holds one byte until the tracker takes it.
  logic              in_valid;
  logic [DATA_W-1:0] in_byte;
  logic              in_last;

  // Output register: holds the verdict until the sink takes it.
  logic              out_valid;
  video_type_e       out_type;

  logic              advance;
  video_type_e       step_type;
  logic [PID_W-1:0]  video_pid;
  logic              reg_hit;

  // The held byte moves on unless it closes a buffer and the result slot is
  // still occupied by a verdict that has not been taken.
  assign advance = in_valid && (!in_last || !out_valid || result_out.ready);
  assign byte_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte <= byte_in.data_byte;
      in_last <= byte_in.last_byte;
    end
  end

  tsvd_packet_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .data_byte  (in_byte),
    .last_byte  (in_last),
    .video_pid  (video_pid),
    .video_type (step_type)
  );

  // A verdict is loaded when the last byte of a buffer passes the tracker; an
  // older verdict must have been taken in the same cycle for that to happen.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_type <= step_type;
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.video_type = out_type;

  // Configuration port: a single register, decoded on the word address.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_VIDEO_PID);

  always_ff @(posedge clk) begin
    if (rst) begin
      video_pid <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      video_pid <= pwdata[PID_W-1:0];
    end
  end

  assign prdata = reg_hit ? {{(APB_DATA_W-PID_W){1'b0}}, video_pid} : '0;

`ifndef SYNTHESIS
  // A verdict only appears after a last byte went through the tracker.
  a_result_from_last : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && in_last))
    else $error("result raised without a last byte");

  // A last byte never overwrites a verdict that the sink has not taken.
  a_no_result_overrun : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_out.ready) |-> !(advance && in_last))
    else $error("pending result overwritten");

  // A held byte that cannot move stays in the input register unchanged.
  a_input_held : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_byte) && $stable(in_last)))
    else $error("stalled input byte lost");

  // Only the three defined codes are ever reported.
  a_type_defined : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_type == VT_NONE || out_type == VT_MPEG2 || out_type == VT_H264))
    else $error("undefined video type reported");
`endif

endmodule

`default_nettype wire
